// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the cipher unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KBC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kbc assertion failed");
`define KBC_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("kbc assertion failed");
`else
`define KBC_ASSERT(lbl, clk, rst_n, prop)
`define KBC_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== rtl/kbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbc_pkg
// Types, tables and byte-level functions for the block cipher unit.
// ----------------------------------------------------------------------------
package kbc_pkg;

    localparam int BLOCK_BYTES    = 16;
    localparam int BLOCK_W        = 8 * BLOCK_BYTES;
    localparam int WORD_W         = 64;
    localparam int KEY_W          = 4 * WORD_W;
    localparam int STEPS_PER_PAIR = 8;
    localparam int KEY_PAIRS      = 4;
    localparam int RK_DEPTH       = 20;
    localparam int RK_AW          = 5;
    localparam int STEP_W         = 5;
    localparam int CNT_W          = 4;
    localparam int ROUND_W        = 4;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd9;
    localparam logic [STEP_W-1:0]  LAST_STEP  = 5'(STEPS_PER_PAIR * KEY_PAIRS - 1);
    localparam logic [CNT_W-1:0]   LIN_LAST   = 4'(BLOCK_BYTES - 1);
    localparam logic [CNT_W-1:0]   WORDS_LAST = 4'd3;

    typedef enum logic [1:0] {
        CFG_KEY_WORD0 = 2'd0,
        CFG_KEY_WORD1 = 2'd1,
        CFG_KEY_WORD2 = 2'd2,
        CFG_KEY_WORD3 = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_LOAD,
        ST_C_LIN,
        ST_F_SUB,
        ST_F_LIN,
        ST_F_MIX,
        ST_KEY_STORE,
        ST_RK_LO,
        ST_RK_HI,
        ST_RK_FIN,
        ST_LIN,
        ST_SUB_INV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic action;
        logic expand;
    } t_eng_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        logic exp_done;
    } t_eng_status;

    typedef struct packed {
        logic              we;
        logic [RK_AW-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic [RK_AW-1:0]  raddr;
    } t_ram_req;

    typedef logic [7:0] t_sbox_tbl [256];

    localparam t_sbox_tbl SBOX = '{
        8'd252, 8'd238, 8'd221, 8'd17,  8'd207, 8'd110, 8'd49,  8'd22,
        8'd251, 8'd196, 8'd250, 8'd218, 8'd35,  8'd197, 8'd4,   8'd77,
        8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46,  8'd153, 8'd186,
        8'd23,  8'd54,  8'd241, 8'd187, 8'd20,  8'd205, 8'd95,  8'd193,
        8'd249, 8'd24,  8'd101, 8'd90,  8'd226, 8'd92,  8'd239, 8'd33,
        8'd129, 8'd28,  8'd60,  8'd66,  8'd139, 8'd1,   8'd142, 8'd79,
        8'd5,   8'd132, 8'd2,   8'd174, 8'd227, 8'd106, 8'd143, 8'd160,
        8'd6,   8'd11,  8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31,
        8'd235, 8'd52,  8'd44,  8'd81,  8'd234, 8'd200, 8'd72,  8'd171,
        8'd242, 8'd42,  8'd104, 8'd162, 8'd253, 8'd58,  8'd206, 8'd204,
        8'd181, 8'd112, 8'd14,  8'd86,  8'd8,   8'd12,  8'd118, 8'd18,
        8'd191, 8'd114, 8'd19,  8'd71,  8'd156, 8'd183, 8'd93,  8'd135,
        8'd21,  8'd161, 8'd150, 8'd41,  8'd16,  8'd123, 8'd154, 8'd199,
        8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158, 8'd178, 8'd177,
        8'd50,  8'd117, 8'd25,  8'd61,  8'd255, 8'd53,  8'd138, 8'd126,
        8'd109, 8'd84,  8'd198, 8'd128, 8'd195, 8'd189, 8'd13,  8'd87,
        8'd223, 8'd245, 8'd36,  8'd169, 8'd62,  8'd168, 8'd67,  8'd201,
        8'd215, 8'd121, 8'd214, 8'd246, 8'd124, 8'd34,  8'd185, 8'd3,
        8'd224, 8'd15,  8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
        8'd220, 8'd232, 8'd40,  8'd80,  8'd78,  8'd51,  8'd10,  8'd74,
        8'd167, 8'd151, 8'd96,  8'd115, 8'd30,  8'd0,   8'd98,  8'd68,
        8'd26,  8'd184, 8'd56,  8'd130, 8'd100, 8'd159, 8'd38,  8'd65,
        8'd173, 8'd69,  8'd70,  8'd146, 8'd39,  8'd94,  8'd85,  8'd47,
        8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59,
        8'd7,   8'd88,  8'd179, 8'd64,  8'd134, 8'd172, 8'd29,  8'd247,
        8'd48,  8'd55,  8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137,
        8'd225, 8'd27,  8'd131, 8'd73,  8'd76,  8'd63,  8'd248, 8'd254,
        8'd141, 8'd83,  8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97,
        8'd32,  8'd113, 8'd103, 8'd164, 8'd45,  8'd43,  8'd9,   8'd91,
        8'd203, 8'd155, 8'd37,  8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
        8'd89,  8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192,
        8'd209, 8'd102, 8'd175, 8'd194, 8'd57,  8'd75,  8'd99,  8'd182
    };

    localparam logic [7:0] LIN_COEF [BLOCK_BYTES] = '{
        8'd1,   8'd148, 8'd32,  8'd133, 8'd16,  8'd194, 8'd192, 8'd1,
        8'd251, 8'd1,   8'd192, 8'd194, 8'd16,  8'd133, 8'd32,  8'd148
    };

    // inverse table, built at elaboration
    function automatic t_sbox_tbl f_inv_table();
        t_sbox_tbl t;
        for (int i = 0; i < 256; i++) begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam t_sbox_tbl SBOX_INV = f_inv_table();

    // GF(2^8) multiply, polynomial x^8+x^7+x^6+x+1
    function automatic logic [7:0] f_gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] aa;
        r  = 8'd0;
        aa = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                r = r ^ aa;
            end
            aa = aa[7] ? ({aa[6:0], 1'b0} ^ 8'hC3) : {aa[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [7:0] f_lin(input logic [BLOCK_W-1:0] a);
        logic [7:0] r;
        r = 8'd0;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            r = r ^ f_gf_mul(a[8*i +: 8], LIN_COEF[i]);
        end
        return r;
    endfunction

    // one shift step of the linear layer
    function automatic logic [BLOCK_W-1:0] f_r(input logic [BLOCK_W-1:0] a);
        return {f_lin(a), a[BLOCK_W-1:8]};
    endfunction

    function automatic logic [BLOCK_W-1:0] f_r_inv(input logic [BLOCK_W-1:0] a);
        logic [BLOCK_W-1:0] t;
        t = {a[BLOCK_W-9:0], a[BLOCK_W-1 -: 8]};
        return {t[BLOCK_W-1:8], f_lin(t)};
    endfunction

    function automatic logic [BLOCK_W-1:0] f_sub(input logic [BLOCK_W-1:0] a);
        logic [BLOCK_W-1:0] o;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            o[8*i +: 8] = SBOX[a[8*i +: 8]];
        end
        return o;
    endfunction

    function automatic logic [BLOCK_W-1:0] f_sub_inv(input logic [BLOCK_W-1:0] a);
        logic [BLOCK_W-1:0] o;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            o[8*i +: 8] = SBOX_INV[a[8*i +: 8]];
        end
        return o;
    endfunction

    // round constant seed: byte 0 holds the step number, counted from one
    function automatic logic [BLOCK_W-1:0] f_seed(input logic [STEP_W-1:0] s);
        return {{(BLOCK_W-8){1'b0}}, 8'(s) + 8'd1};
    endfunction

endpackage

// ===== rtl/kuznyechik_block_cipher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuznyechik_block_cipher_unit
// 128-bit block cipher, 256-bit key, round keys held in a small key store.
// ----------------------------------------------------------------------------
// Usage:
//  - Key: four 64-bit words written on the config channel (i_cfg_valid /
//    o_cfg_ready, index and data); a transfer happens when both are high.
//    Any key write marks the round keys stale. Write only while idle;
//    o_cfg_ready is low while busy or while start is high.
//  - Blocks: a command is taken when start is high and busy is low;
//    i_action selects encrypt (0) or decrypt (1). busy stays high until
//    the result has been shown.
//  - Result: o_result_low/high valid for exactly one cycle with
//    o_result_valid; the receiver cannot stall, so it must take it then.
//  - Timing: one shift step of the linear layer per cycle. The first
//    block after reset or a key write first expands the keys: 32 Feistel
//    steps plus 20 key store writes. The round key store has one read
//    port, so each round key is fetched in two halves.
//  - Reset: synchronous, active low; key words clear to zero and the round
//    keys are marked stale. The key store itself is not cleared.
// ----------------------------------------------------------------------------
module kuznyechik_block_cipher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    output logic        o_result_valid,
    output logic [63:0] o_result_low,
    output logic [63:0] o_result_high,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [63:0] r_key_word0;
    logic [63:0] r_key_word1;
    logic [63:0] r_key_word2;
    logic [63:0] r_key_word3;
    logic        r_keys_valid;

    kbc_pkg::t_eng_cmd           eng_cmd;
    kbc_pkg::t_eng_status        eng_status;
    logic [kbc_pkg::BLOCK_W-1:0] result;
    logic                        cfg_xfer;

    assign busy        = eng_status.busy;
    // a key write never shares an edge with a block transfer
    assign o_cfg_ready = !eng_status.busy && !start;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    // keys are stale after reset or any key write; expansion runs first
    assign eng_cmd.start  = start && !busy;
    assign eng_cmd.action = i_action;
    assign eng_cmd.expand = !r_keys_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_word0  <= '0;
            r_key_word1  <= '0;
            r_key_word2  <= '0;
            r_key_word3  <= '0;
            r_keys_valid <= 1'b0;
        end else if (cfg_xfer) begin
            unique case (kbc_pkg::t_cfg_reg'(i_cfg_index))
                kbc_pkg::CFG_KEY_WORD0: r_key_word0 <= i_cfg_data;
                kbc_pkg::CFG_KEY_WORD1: r_key_word1 <= i_cfg_data;
                kbc_pkg::CFG_KEY_WORD2: r_key_word2 <= i_cfg_data;
                kbc_pkg::CFG_KEY_WORD3: r_key_word3 <= i_cfg_data;
            endcase
            r_keys_valid <= 1'b0;
        end else if (eng_status.exp_done) begin
            r_keys_valid <= 1'b1;
        end
    end

    kbc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (eng_cmd),
        .i_block  ({i_block_high, i_block_low}),
        .i_key    ({r_key_word3, r_key_word2, r_key_word1, r_key_word0}),
        .o_status (eng_status),
        .o_result (result)
    );

    assign o_result_valid = eng_status.done;
    assign o_result_low   = result[63:0];
    assign o_result_high  = result[127:64];

endmodule

// ===== rtl/kbc_rk_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbc_rk_ram
// Round key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kbc_rk_ram (
    input  logic                         i_clk,
    input  kbc_pkg::t_ram_req            i_req,
    output logic [kbc_pkg::WORD_W-1:0]   o_rdata
);

    logic [kbc_pkg::WORD_W-1:0] r_mem [kbc_pkg::RK_DEPTH];
    logic [kbc_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/kbc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbc_engine
// Sequencer and datapath: key expansion and block rounds around the key store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kbc_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kbc_pkg::t_eng_cmd             i_cmd,
    input  logic [kbc_pkg::BLOCK_W-1:0]   i_block,
    input  logic [kbc_pkg::KEY_W-1:0]     i_key,
    output kbc_pkg::t_eng_status          o_status,
    output logic [kbc_pkg::BLOCK_W-1:0]   o_result
);

    kbc_pkg::t_state r_state;
    kbc_pkg::t_state n_state;

    logic [kbc_pkg::CNT_W-1:0]   r_cnt;
    logic [kbc_pkg::STEP_W-1:0]  r_step;
    logic [kbc_pkg::ROUND_W-1:0] r_round;
    logic                        r_action;

    logic [kbc_pkg::BLOCK_W-1:0] r_a;
    logic [kbc_pkg::BLOCK_W-1:0] r_blk;
    logic [kbc_pkg::BLOCK_W-1:0] r_x;
    logic [kbc_pkg::BLOCK_W-1:0] r_y;

    kbc_pkg::t_ram_req           ram_req;
    logic [kbc_pkg::WORD_W-1:0]  rdata;
    logic                        last_round;
    logic                        pair_end;
    logic                        words_end;
    logic [kbc_pkg::BLOCK_W-1:0] rk_xor;

    kbc_rk_ram u_rk_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    assign last_round = r_action ? (r_round == '0) : (r_round == kbc_pkg::LAST_ROUND);
    assign pair_end   = (r_step[2:0] == 3'(kbc_pkg::STEPS_PER_PAIR - 1));
    assign words_end  = (r_cnt == kbc_pkg::WORDS_LAST);
    assign rk_xor     = {r_a[kbc_pkg::BLOCK_W-1:kbc_pkg::WORD_W] ^ rdata,
                         r_a[kbc_pkg::WORD_W-1:0]};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kbc_pkg::ST_IDLE: begin
                if (i_cmd.start) begin
                    n_state = i_cmd.expand ? kbc_pkg::ST_KEY_LOAD : kbc_pkg::ST_RK_LO;
                end
            end
            kbc_pkg::ST_KEY_LOAD: begin
                if (words_end) n_state = kbc_pkg::ST_C_LIN;
            end
            kbc_pkg::ST_C_LIN: begin
                if (r_cnt == kbc_pkg::LIN_LAST) n_state = kbc_pkg::ST_F_SUB;
            end
            kbc_pkg::ST_F_SUB:  n_state = kbc_pkg::ST_F_LIN;
            kbc_pkg::ST_F_LIN: begin
                if (r_cnt == kbc_pkg::LIN_LAST) n_state = kbc_pkg::ST_F_MIX;
            end
            kbc_pkg::ST_F_MIX: begin
                n_state = pair_end ? kbc_pkg::ST_KEY_STORE : kbc_pkg::ST_C_LIN;
            end
            kbc_pkg::ST_KEY_STORE: begin
                if (words_end) begin
                    n_state = (r_step == kbc_pkg::LAST_STEP) ? kbc_pkg::ST_RK_LO
                                                             : kbc_pkg::ST_C_LIN;
                end
            end
            kbc_pkg::ST_RK_LO:  n_state = kbc_pkg::ST_RK_HI;
            kbc_pkg::ST_RK_HI:  n_state = kbc_pkg::ST_RK_FIN;
            kbc_pkg::ST_RK_FIN: n_state = last_round ? kbc_pkg::ST_DONE : kbc_pkg::ST_LIN;
            kbc_pkg::ST_LIN: begin
                if (r_cnt == kbc_pkg::LIN_LAST) begin
                    n_state = r_action ? kbc_pkg::ST_SUB_INV : kbc_pkg::ST_RK_LO;
                end
            end
            kbc_pkg::ST_SUB_INV: n_state = kbc_pkg::ST_RK_LO;
            kbc_pkg::ST_DONE:    n_state = kbc_pkg::ST_IDLE;
            default:             n_state = kbc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ram_req.we    = (r_state == kbc_pkg::ST_KEY_LOAD) || (r_state == kbc_pkg::ST_KEY_STORE);
        ram_req.waddr = (r_state == kbc_pkg::ST_KEY_LOAD) ? {3'd0, r_cnt[1:0]}
                                                          : {3'(r_step[4:3]) + 3'd1, r_cnt[1:0]};
        unique case (r_cnt[1:0])
            2'd0:    ram_req.wdata = r_x[kbc_pkg::WORD_W-1:0];
            2'd1:    ram_req.wdata = r_x[kbc_pkg::BLOCK_W-1:kbc_pkg::WORD_W];
            2'd2:    ram_req.wdata = r_y[kbc_pkg::WORD_W-1:0];
            default: ram_req.wdata = r_y[kbc_pkg::BLOCK_W-1:kbc_pkg::WORD_W];
        endcase
        ram_req.raddr = {r_round, (r_state == kbc_pkg::ST_RK_HI)};

        o_status.busy     = (r_state != kbc_pkg::ST_IDLE);
        o_status.done     = (r_state == kbc_pkg::ST_DONE);
        o_status.exp_done = (r_state == kbc_pkg::ST_KEY_STORE) && words_end
                            && (r_step == kbc_pkg::LAST_STEP);
    end

    assign o_result = r_a;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kbc_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_step   <= '0;
            r_round  <= '0;
            r_action <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? '0 : r_cnt + 4'd1;
            unique case (r_state)
                kbc_pkg::ST_IDLE: begin
                    if (i_cmd.start) begin
                        r_step   <= '0;
                        r_action <= i_cmd.action;
                        r_round  <= i_cmd.action ? kbc_pkg::LAST_ROUND : '0;
                    end
                end
                kbc_pkg::ST_F_MIX: begin
                    if (!pair_end) r_step <= r_step + 5'd1;
                end
                kbc_pkg::ST_KEY_STORE: begin
                    if (words_end && (r_step != kbc_pkg::LAST_STEP)) r_step <= r_step + 5'd1;
                end
                kbc_pkg::ST_LIN: begin
                    if ((r_cnt == kbc_pkg::LIN_LAST) && !r_action) r_round <= r_round + 4'd1;
                end
                kbc_pkg::ST_SUB_INV: r_round <= r_round - 4'd1;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            kbc_pkg::ST_IDLE: begin
                r_a   <= i_block;
                r_blk <= i_block;
                // x holds key bytes 16..31, y key bytes 0..15
                r_x   <= i_key[kbc_pkg::KEY_W-1:kbc_pkg::BLOCK_W];
                r_y   <= i_key[kbc_pkg::BLOCK_W-1:0];
            end
            kbc_pkg::ST_KEY_LOAD: begin
                if (words_end) r_a <= kbc_pkg::f_seed(r_step);
            end
            kbc_pkg::ST_C_LIN, kbc_pkg::ST_F_LIN: r_a <= kbc_pkg::f_r(r_a);
            kbc_pkg::ST_F_SUB: r_a <= kbc_pkg::f_sub(r_x ^ r_a);
            kbc_pkg::ST_F_MIX: begin
                r_x <= r_a ^ r_y;
                r_y <= r_x;
                if (!pair_end) r_a <= kbc_pkg::f_seed(r_step + 5'd1);
            end
            kbc_pkg::ST_KEY_STORE: begin
                if (words_end) begin
                    r_a <= (r_step == kbc_pkg::LAST_STEP) ? r_blk
                                                          : kbc_pkg::f_seed(r_step + 5'd1);
                end
            end
            kbc_pkg::ST_RK_HI: begin
                r_a[kbc_pkg::WORD_W-1:0] <= r_a[kbc_pkg::WORD_W-1:0] ^ rdata;
            end
            kbc_pkg::ST_RK_FIN: begin
                r_a <= (last_round || r_action) ? rk_xor : kbc_pkg::f_sub(rk_xor);
            end
            kbc_pkg::ST_LIN: r_a <= r_action ? kbc_pkg::f_r_inv(r_a) : kbc_pkg::f_r(r_a);
            kbc_pkg::ST_SUB_INV: r_a <= kbc_pkg::f_sub_inv(r_a);
            default: ;
        endcase
    end

    `KBC_ASSERT(a_we_only_expand, i_clk, i_rst_n, ram_req.we |-> (r_state == kbc_pkg::ST_KEY_LOAD || r_state == kbc_pkg::ST_KEY_STORE))
    `KBC_ASSERT(a_done_after_fin, i_clk, i_rst_n, o_status.done |-> $past(r_state) == kbc_pkg::ST_RK_FIN)
    `KBC_ASSERT(a_exp_to_rounds, i_clk, i_rst_n, o_status.exp_done |=> r_state == kbc_pkg::ST_RK_LO)
    `KBC_ASSERT(a_lin_from_zero, i_clk, i_rst_n, r_state == kbc_pkg::ST_F_SUB |=> r_cnt == '0)
    `KBC_ASSERT_NR(a_waddr_range, i_clk, ram_req.we |-> ram_req.waddr < 5'(kbc_pkg::RK_DEPTH))

endmodule

// ===== verif/tb_kuznyechik_block_cipher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kuznyechik_block_cipher_unit
// Self-checking bench for the 128-bit block cipher unit. A behavioural
// cipher inside the bench expands its own round keys and works out every
// encrypt and decrypt result, which is then matched against the strobed
// output, oldest first, over several keys including the all-zero and
// all-ones extremes.
// ----------------------------------------------------------------------------
module tb_kuznyechik_block_cipher_unit;

    localparam bit ACT_ENCRYPT = 1'b0;
    localparam bit ACT_DECRYPT = 1'b1;
    localparam int END_DRAIN_CYCLES = 400;

    typedef struct {
        logic [63:0] low;
        logic [63:0] high;
    } t_block_result;

    // substitution table of the standard
    localparam int PI_TBL [256] = '{
        252,238,221,17,207,110,49,22,251,196,250,218,35,197,4,77,
        233,119,240,219,147,46,153,186,23,54,241,187,20,205,95,193,
        249,24,101,90,226,92,239,33,129,28,60,66,139,1,142,79,
        5,132,2,174,227,106,143,160,6,11,237,152,127,212,211,31,
        235,52,44,81,234,200,72,171,242,42,104,162,253,58,206,204,
        181,112,14,86,8,12,118,18,191,114,19,71,156,183,93,135,
        21,161,150,41,16,123,154,199,243,145,120,111,157,158,178,177,
        50,117,25,61,255,53,138,126,109,84,198,128,195,189,13,87,
        223,245,36,169,62,168,67,201,215,121,214,246,124,34,185,3,
        224,15,236,222,122,148,176,188,220,232,40,80,78,51,10,74,
        167,151,96,115,30,0,98,68,26,184,56,130,100,159,38,65,
        173,69,70,146,39,94,85,47,140,163,165,125,105,213,149,59,
        7,88,179,64,134,172,29,247,48,55,107,228,136,217,231,137,
        225,27,131,73,76,63,248,254,141,83,170,144,202,216,133,97,
        32,113,103,164,45,43,9,91,203,155,37,208,190,229,108,82,
        89,166,116,210,230,244,180,192,209,102,175,194,57,75,99,182
    };
    localparam int MIX_COEF [16] = '{
        1,148,32,133,16,194,192,1,251,1,192,194,16,133,32,148
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_action;
    logic [63:0] i_block_low;
    logic [63:0] i_block_high;
    logic        o_result_valid;
    logic [63:0] o_result_low;
    logic [63:0] o_result_high;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    // bench copy of the key and schedule
    logic [63:0]  key_words [4];
    logic [127:0] sched_keys [10];
    bit           sched_stale;
    logic [7:0]   pi_inv [256];

    t_block_result pending_results [$];
    int            n_errors;

    kuznyechik_block_cipher_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_block_low    (i_block_low),
        .i_block_high   (i_block_high),
        .o_result_valid (o_result_valid),
        .o_result_low   (o_result_low),
        .o_result_high  (o_result_high),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- behavioural cipher ----------------

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'd0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= a;
            a = a[7] ? ({a[6:0], 1'b0} ^ 8'hC3) : {a[6:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic logic [7:0] mix_byte(input logic [127:0] s);
        logic [7:0] acc;
        acc = 8'd0;
        for (int k = 0; k < 16; k++) acc ^= gf_times(s[8*k +: 8], 8'(MIX_COEF[k]));
        return acc;
    endfunction

    // sixteen shift steps: byte 0 drops out, new byte enters at the top
    function automatic logic [127:0] mix_fwd(input logic [127:0] s);
        for (int n = 0; n < 16; n++) s = {mix_byte(s), s[127:8]};
        return s;
    endfunction

    function automatic logic [127:0] mix_rev(input logic [127:0] s);
        for (int n = 0; n < 16; n++) begin
            s = {s[119:0], s[127:120]};
            s[7:0] = mix_byte(s);
        end
        return s;
    endfunction

    function automatic logic [127:0] subst(input logic [127:0] s, input bit rev);
        for (int k = 0; k < 16; k++)
            s[8*k +: 8] = rev ? pi_inv[s[8*k +: 8]] : 8'(PI_TBL[s[8*k +: 8]]);
        return s;
    endfunction

    task automatic expand_schedule();
        logic [127:0] x, y, t, c;
        sched_keys[0] = {key_words[3], key_words[2]};
        sched_keys[1] = {key_words[1], key_words[0]};
        for (int p = 0; p < 4; p++) begin
            x = sched_keys[2*p];
            y = sched_keys[2*p+1];
            for (int j = 0; j < 8; j++) begin
                c = mix_fwd(128'(8*p + j + 1));
                t = mix_fwd(subst(x ^ c, 1'b0)) ^ y;
                y = x;
                x = t;
            end
            sched_keys[2*p+2] = x;
            sched_keys[2*p+3] = y;
        end
        sched_stale = 1'b0;
    endtask

    task automatic predict_block(input bit act, input logic [63:0] lo, input logic [63:0] hi);
        logic [127:0]  s;
        t_block_result r;
        if (sched_stale) expand_schedule();
        s = {hi, lo};
        if (act == ACT_ENCRYPT) begin
            for (int k = 0; k < 9; k++) s = mix_fwd(subst(s ^ sched_keys[k], 1'b0));
            s ^= sched_keys[9];
        end else begin
            for (int k = 9; k > 0; k--) s = subst(mix_rev(s ^ sched_keys[k]), 1'b1);
            s ^= sched_keys[0];
        end
        r.low  = s[63:0];
        r.high = s[127:64];
        pending_results.push_back(r);
    endtask

    // ---------------- drivers ----------------

    // one block transfer; returns at the falling edge after acceptance
    task automatic send_block(input bit act, input logic [63:0] lo, input logic [63:0] hi);
        int gap;
        gap   = $urandom_range(0, 4);
        start = 1'b0;
        repeat (gap) @(negedge i_clk);
        start        = 1'b1;
        i_action     = act;
        i_block_low  = lo;
        i_block_high = hi;
        do @(posedge i_clk); while (busy);
        predict_block(act, lo, hi);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // key write; only ever called once the unit has drained
    task automatic write_key_word(input kbc_pkg::t_cfg_reg idx, input logic [63:0] val);
        repeat ($urandom_range(0, 4)) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        key_words[idx] = val;
        sched_stale    = 1'b1;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_key(input logic [255:0] k);
        wait_drained();
        for (int w = 0; w < 4; w++) write_key_word(kbc_pkg::t_cfg_reg'(w), k[64*w +: 64]);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ---------------- result check ----------------

    always @(posedge i_clk) begin
        t_block_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h_%h", $time, o_result_high, o_result_low);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_result_low !== want.low) begin
                    $display("%0t: result_low expected %h actual %h",
                             $time, want.low, o_result_low);
                    n_errors++;
                end
                if (o_result_high !== want.high) begin
                    $display("%0t: result_high expected %h actual %h",
                             $time, want.high, o_result_high);
                    n_errors++;
                end
            end
        end
    end

    // ---------------- tests ----------------

    // blocks before any key write run on the all-zero reset key
    task automatic test_reset_key();
        send_block(ACT_ENCRYPT, 64'd0, 64'd0);
        send_block(ACT_DECRYPT, 64'd0, 64'd0);
        send_block(ACT_ENCRYPT, '1, '1);
    endtask

    // field extremes under the all-ones and an explicit all-zero key
    task automatic test_key_extremes();
        load_key('1);
        send_block(ACT_ENCRYPT, 64'd0, 64'd0);
        send_block(ACT_ENCRYPT, '1, '1);
        send_block(ACT_DECRYPT, '1, '1);
        send_block(ACT_DECRYPT, 64'd0, 64'd0);
        send_block(ACT_ENCRYPT, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
        load_key('0);
        send_block(ACT_ENCRYPT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_block(ACT_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    endtask

    // standard-style key; a single-word write must also force re-expansion
    task automatic test_single_word_rekey();
        load_key(256'h8899aabbccddeeff0011223344556677_fedcba98765432100123456789abcdef);
        send_block(ACT_ENCRYPT, 64'hffeeddccbbaa9988, 64'h1122334455667700);
        send_block(ACT_DECRYPT, 64'h5a468d42b9d4edcd, 64'h7f679d90bebc2430);
        for (int w = 0; w < 4; w++) begin
            wait_drained();
            write_key_word(kbc_pkg::t_cfg_reg'(w), rand64());
            send_block(ACT_ENCRYPT, rand64(), rand64());
            send_block(ACT_DECRYPT, rand64(), rand64());
        end
    endtask

    // sender holds off until the unit has returned everything
    task automatic test_drain_pause();
        for (int n = 0; n < 4; n++) begin
            send_block(bit'($urandom_range(0, 1)), rand64(), rand64());
            wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        int burst;
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 3))
                0: load_key('1);
                1: begin
                    wait_drained();
                    write_key_word(kbc_pkg::t_cfg_reg'($urandom_range(0, 3)), rand64());
                end
                default: load_key({rand64(), rand64(), rand64(), rand64()});
            endcase
            burst = $urandom_range(35, 50);
            for (int n = 0; n < burst; n++) begin
                // mostly full-range data, sometimes sparse or dense patterns
                case ($urandom_range(0, 7))
                    0: send_block(bit'($urandom_range(0, 1)), rand64() & rand64(),
                                  rand64() & rand64());
                    1: send_block(bit'($urandom_range(0, 1)), rand64() | rand64(),
                                  rand64() | rand64());
                    default: send_block(bit'($urandom_range(0, 1)), rand64(), rand64());
                endcase
            end
        end
    endtask

    // ---------------- sequence ----------------

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_action     = ACT_ENCRYPT;
        i_block_low  = '0;
        i_block_high = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = kbc_pkg::CFG_KEY_WORD0;
        i_cfg_data   = '0;
        n_errors     = 0;
        sched_stale  = 1'b1;
        for (int w = 0; w < 4; w++) key_words[w] = '0;
        for (int v = 0; v < 256; v++) pi_inv[8'(PI_TBL[v])] = 8'(v);
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_key();
        test_key_extremes();
        test_single_word_rekey();
        test_drain_pause();
        test_random_traffic();

        wait_drained();
        repeat (END_DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog: well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
